[src/dtc_pkg.sv]
// Shared types, constants and helper functions for the date word counter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dtc_pkg;

  // Width of the running count of valid words. The reported count is the
  // low sixteen bits of this, zero-extended when narrower.
  localparam int unsigned CountBits = 16;
  localparam int unsigned OutBits   = 16;

  // Depth of the queue between the classifier and the word engine.
  // It must be a power of two.
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrBits  = $clog2(QDepth);
  localparam int unsigned QCntBits  = $clog2(QDepth + 1);

  // Word layout: DD/MM/YYYY.
  localparam logic [3:0] DateLen    = 4'd10;
  localparam logic [3:0] PosCap     = 4'd11;
  localparam logic [3:0] PosSlash0  = 4'd2;
  localparam logic [3:0] PosSlash1  = 4'd5;
  localparam logic [3:0] PosMonth   = 4'd3;
  localparam logic [3:0] PosYear    = 4'd6;

  // Byte codes.
  localparam logic [7:0] CharNul    = 8'd0;
  localparam logic [7:0] CharSpace  = 8'd32;
  localparam logic [7:0] CharSlash  = 8'd47;
  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharNine   = 8'd57;

  localparam logic [6:0] MonthMax   = 7'd12;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_SPACE,
    KIND_END
  } kind_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    kind_e      kind;
    logic       is_slash;
    logic       is_digit;
    logic [3:0] digit;
  } tok_t;

  // Number of days in a month (1 to 12); February follows the leap flag.
  function automatic logic [4:0] month_limit(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    begin
      case (month)
        4'd2:    days = leap ? 5'd29 : 5'd28;
        4'd4:    days = 5'd30;
        4'd6:    days = 5'd30;
        4'd9:    days = 5'd30;
        4'd11:   days = 5'd30;
        default: days = 5'd31;
      endcase
      return days;
    end
  endfunction

  // True when the two-digit number (tens, units) is a multiple of four.
  // Since 10 is 2 mod 4, the value mod 4 is (2 * tens + units) mod 4.
  function automatic logic pair_div4(input logic [3:0] tens, input logic [3:0] units);
    logic [1:0] sum;
    begin
      sum = units[1:0] + {tens[0], 1'b0};
      return (sum == 2'd0);
    end
  endfunction

endpackage

`default_nettype wire

[src/date_token_counter.sv]
// Date word counter. Bytes of a string arrive one per request on the input
// channel; a space separates words and a NUL ends the string. Each word that
// reads DD/MM/YYYY with a real calendar date (Gregorian leap years) is counted,
// the count saturating at its maximum, and the NUL yields one result request
// carrying the count, after which all state is clear for the next string.
// The block takes one byte per clock cycle: a classifier on the input side
// feeds a two-entry queue, and the word engine behind it retires one queued
// byte per cycle, so a byte is registered in the queue before it reaches the
// engine. A result sits in an output register; only a NUL that finds that
// register still held by a stalled result waits in the queue, and the input
// stalls once the queue holds two bytes. Nothing else limits the rate.
`default_nettype none

module date_token_counter (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  char_code_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] date_count_o
);
  import dtc_pkg::*;

  tok_t  push_tok;
  tok_t  head_tok;
  logic  q_push, q_pop, q_full, q_empty;

  // Classifier: turns each accepted byte into a token for the queue.
  dtc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_tok_o     (push_tok)
  );

  // The queue lets the input keep flowing while a result waits downstream.
  dtc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_tok_i (push_tok),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .pop_i      (q_pop),
    .head_tok_o (head_tok)
  );

  // Word engine: date checking, counting and the result register.
  dtc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_tok_i      (head_tok),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .date_count_o (date_count_o)
  );

endmodule

`default_nettype wire

[src/dtc_queue.sv]
// Small FIFO of classified bytes between the classifier and the word engine.
// Depends on dtc_pkg for the entry type and depth.
`default_nettype none

module dtc_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  dtc_pkg::tok_t  push_tok_i,
  output logic           full_o,
  output logic           empty_o,
  input  wire            pop_i,
  output dtc_pkg::tok_t  head_tok_o
);
  import dtc_pkg::*;

  tok_t                 mem_q [QDepth];
  logic [QPtrBits-1:0]  wptr_q, wptr_d;
  logic [QPtrBits-1:0]  rptr_q, rptr_d;
  logic [QCntBits-1:0]  count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o     = (count_q == QCntBits'(QDepth));
  assign empty_o    = (count_q == '0);
  assign head_tok_o = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_tok_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntBits'(QDepth))
    else $error("queue count exceeds depth");
`endif

endmodule

`default_nettype wire

[src/dtc_front.sv]
// Input side: takes bytes from the request channel and classifies them.
// Depends on dtc_pkg; feeds dtc_queue.
`default_nettype none

module dtc_front (
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  wire [7:0]      char_code_i,
  input  wire            q_full_i,
  output logic           q_push_o,
  output dtc_pkg::tok_t  q_tok_o
);
  import dtc_pkg::*;

  logic [7:0] digit_wide;

  // The stall comes straight from the registered queue fill level.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign digit_wide = char_code_i - CharZero;

  always_comb begin
    q_tok_o.is_slash = (char_code_i == CharSlash);
    q_tok_o.is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);
    q_tok_o.digit    = digit_wide[3:0];
    if (char_code_i == CharNul) begin
      q_tok_o.kind = KIND_END;
    end else if (char_code_i == CharSpace) begin
      q_tok_o.kind = KIND_SPACE;
    end else begin
      q_tok_o.kind = KIND_CHAR;
    end
  end

endmodule

`default_nettype wire

[src/dtc_back.sv]
// Word engine: consumes classified bytes, tracks the open word, checks dates
// on close and keeps the count. Holds the output register. Depends on dtc_pkg.
`default_nettype none

module dtc_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_empty_i,
  input  dtc_pkg::tok_t        q_tok_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [dtc_pkg::OutBits-1:0] date_count_o
);
  import dtc_pkg::*;

  logic                  in_token_q, in_token_d;
  logic [3:0]            pos_q, pos_d;
  logic                  bad_q, bad_d;
  logic [6:0]            day_q, day_d;
  logic [6:0]            mon_q, mon_d;
  logic [3:0]            yd_q [4];
  logic [3:0]            yd_d [4];
  logic [CountBits-1:0]  total_q, total_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutBits-1:0]    count_q, count_d;

  logic                  out_free;
  logic                  leap, date_ok, bump;
  logic [4:0]            limit;
  logic [3:0]            cur_pos;
  logic [6:0]            cur_day, cur_mon;
  logic [10:0]           day_acc, mon_acc;
  logic [CountBits-1:0]  total_closed;
  logic [3:0]            yidx;

  assign out_free = !out_valid_q || !out_stall_i;
  // An end marker needs room in the output register; other bytes never wait.
  assign q_pop_o  = !q_empty_i && ((q_tok_i.kind != KIND_END) || out_free);

  // Gregorian leap rule on the year digits: a year ending in 00 leaps when
  // its century is a multiple of four, any other when its last two digits are.
  assign leap = ((yd_q[2] == 4'd0) && (yd_q[3] == 4'd0)) ? pair_div4(yd_q[0], yd_q[1])
                                                         : pair_div4(yd_q[2], yd_q[3]);
  assign limit = month_limit(mon_q[3:0], leap);

  assign date_ok = (pos_q == DateLen) && !bad_q
                && (mon_q >= 7'd1) && (mon_q <= MonthMax)
                && (day_q >= 7'd1) && (day_q <= {2'b00, limit});

  assign bump         = in_token_q && date_ok && (total_q != '1);
  assign total_closed = bump ? total_q + 1'b1 : total_q;

  // A byte that opens a word sees a cleared word state.
  assign cur_pos = in_token_q ? pos_q : 4'd0;
  assign cur_day = in_token_q ? day_q : 7'd0;
  assign cur_mon = in_token_q ? mon_q : 7'd0;
  assign day_acc = (11'(cur_day) << 3) + (11'(cur_day) << 1) + 11'(q_tok_i.digit);
  assign mon_acc = (11'(cur_mon) << 3) + (11'(cur_mon) << 1) + 11'(q_tok_i.digit);
  assign yidx    = cur_pos - PosYear;

  always_comb begin
    in_token_d  = in_token_q;
    pos_d       = pos_q;
    bad_d       = bad_q;
    day_d       = day_q;
    mon_d       = mon_q;
    yd_d        = yd_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    count_d     = count_q;

    if (q_pop_o) begin
      case (q_tok_i.kind)
        KIND_CHAR: begin
          in_token_d = 1'b1;
          bad_d      = in_token_q ? bad_q : 1'b0;
          day_d      = cur_day;
          mon_d      = cur_mon;
          if (!in_token_q) begin
            yd_d = '{default: 4'd0};
          end
          if (cur_pos < DateLen) begin
            if ((cur_pos == PosSlash0) || (cur_pos == PosSlash1)) begin
              if (!q_tok_i.is_slash) begin
                bad_d = 1'b1;
              end
            end else if (!q_tok_i.is_digit) begin
              bad_d = 1'b1;
            end else if (cur_pos < PosSlash0) begin
              day_d = day_acc[6:0];
            end else if (cur_pos < PosSlash1) begin
              mon_d = mon_acc[6:0];
            end else begin
              yd_d[yidx[1:0]] = q_tok_i.digit;
            end
          end
          pos_d = (cur_pos < PosCap) ? cur_pos + 1'b1 : cur_pos;
        end
        KIND_SPACE: begin
          in_token_d = 1'b0;
          pos_d      = 4'd0;
          bad_d      = 1'b0;
          day_d      = 7'd0;
          mon_d      = 7'd0;
          yd_d       = '{default: 4'd0};
          total_d    = total_closed;
        end
        KIND_END: begin
          in_token_d  = 1'b0;
          pos_d       = 4'd0;
          bad_d       = 1'b0;
          day_d       = 7'd0;
          mon_d       = 7'd0;
          yd_d        = '{default: 4'd0};
          total_d     = '0;
          out_valid_d = 1'b1;
          count_d     = OutBits'(total_closed);
        end
        default: begin
          in_token_d = in_token_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q  <= 1'b0;
      pos_q       <= 4'd0;
      bad_q       <= 1'b0;
      day_q       <= 7'd0;
      mon_q       <= 7'd0;
      yd_q        <= '{default: 4'd0};
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_token_q  <= in_token_d;
      pos_q       <= pos_d;
      bad_q       <= bad_d;
      day_q       <= day_d;
      mon_q       <= mon_d;
      yd_q        <= yd_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign date_count_o = count_q;

`ifndef SYNTHESIS
  a_pos_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosCap)
    else $error("word position ran past its cap");

  a_idle_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_token_q |-> (pos_q == 4'd0) && !bad_q)
    else $error("word state not cleared outside a word");

  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && (q_tok_i.kind == KIND_END) |=> out_valid_q && (total_q == '0) && !in_token_q)
    else $error("end of string did not post a result and clear the count");
`endif

endmodule

`default_nettype wire
